// ===== rtl/grc_pkg.sv =====
// package of the grid ray caster: constants, transaction types, states and helper functions
`default_nettype none

package grc_pkg;

    // geometry and march limits
    localparam int GRID_CELLS = 10;
    localparam int CELL_SIZE  = 60;
    localparam int MAX_STEPS  = 10;
    localparam int ANGLE_BITS = 12;

    // transaction field widths
    localparam int ROW_IDX_W  = 4;
    localparam int ROW_BITS_W = 10;
    localparam int COORD_W    = 16;

    // fixed point coordinates, Q10.6 pixels
    localparam int FRAC_ONE   = 64;
    localparam int CELL_Q     = CELL_SIZE * FRAC_ONE;
    localparam int WORLD_Q    = GRID_CELLS * CELL_Q;
    localparam int COORD_TOP  = WORLD_Q - FRAC_ONE;
    localparam int NUDGE_Q    = 6;

    // slopes in Q7.8
    localparam int SLOPE_FRAC = 8;
    localparam int SLOPE_CUT  = 58 << SLOPE_FRAC;
    localparam int SLOPE_SAT  = 57 << SLOPE_FRAC;
    localparam int SLOPE_W    = 16;

    // angle phase, 16 bits per turn
    localparam int PHASE_W        = 16;
    localparam int RES_W          = PHASE_W - 2;
    localparam int PHASE_QUARTER  = 1 << RES_W;
    localparam int PHASE_HALF     = 2 << RES_W;
    localparam int PHASE_3QUARTER = 3 << RES_W;

    // cordic rotator
    localparam int CORDIC_STEPS = 16;
    localparam int CORDIC_START = 16384;
    localparam int ITER_W       = $clog2(CORDIC_STEPS);
    localparam int CORDIC_W     = 18;
    localparam int TURN_W       = 14;

    // divider and shared multiplier
    localparam int MAG_W   = 17;
    localparam int QUO_W   = 15;
    localparam int QCNT_W  = $clog2(QUO_W);
    localparam int MUL_W   = 18;
    localparam int PROD_W  = 2 * MUL_W;

    // march and distance counters
    localparam int CELL_W  = $clog2(GRID_CELLS);
    localparam int STEP_W  = $clog2(MAX_STEPS + 1);
    localparam int DIST_W  = 3;

    // operation codes
    localparam logic OP_ROW_WRITE = 1'b0;
    localparam logic OP_CAST      = 1'b1;

    typedef struct packed {
        logic                  operation;
        logic [ROW_IDX_W-1:0]  row_index;
        logic [ROW_BITS_W-1:0] row_bits;
        logic [COORD_W-1:0]    player_x;
        logic [COORD_W-1:0]    player_y;
        logic [ANGLE_BITS-1:0] ray_angle;
    } grc_req_t;

    typedef struct packed {
        logic [COORD_W-1:0] hit_x;
        logic [COORD_W-1:0] hit_y;
        logic               hit_on_vertical;
    } grc_rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CORDIC,
        ST_SETUP,
        ST_DIV_INIT,
        ST_DIV_RUN,
        ST_MARCH_INIT,
        ST_MARCH_MUL,
        ST_MARCH_ADD,
        ST_MARCH_TEST,
        ST_DIST,
        ST_DONE
    } grc_state_t;

    // arctangent table in 1/65536 turn
    function automatic logic [TURN_W-1:0] cordic_turn(input logic [ITER_W-1:0] idx);
        logic [TURN_W-1:0] t;
        unique case (idx)
            4'd0:    t = 14'd8192;
            4'd1:    t = 14'd4836;
            4'd2:    t = 14'd2555;
            4'd3:    t = 14'd1297;
            4'd4:    t = 14'd651;
            4'd5:    t = 14'd326;
            4'd6:    t = 14'd163;
            4'd7:    t = 14'd81;
            4'd8:    t = 14'd41;
            4'd9:    t = 14'd20;
            4'd10:   t = 14'd10;
            4'd11:   t = 14'd5;
            4'd12:   t = 14'd3;
            4'd13:   t = 14'd1;
            4'd14:   t = 14'd1;
            default: t = '0;
        endcase
        return t;
    endfunction

    // cell index of an in-world coordinate, by parallel compares against grid lines
    function automatic logic [CELL_W-1:0] cell_of(input logic [COORD_W-1:0] v);
        logic [CELL_W-1:0] n;
        n = '0;
        for (int k = 1; k < GRID_CELLS; k++) begin
            if (int'(v) >= k * CELL_Q) begin
                n = n + 1'b1;
            end
        end
        return n;
    endfunction

    // coordinate of the left or top line of a cell
    function automatic logic [COORD_W-1:0] cell_base(input logic [CELL_W-1:0] c);
        return COORD_W'(int'(c) * CELL_Q);
    endfunction

    // origin saturation to the last pixel of the world
    function automatic logic [COORD_W-1:0] clamp_in(input logic [COORD_W-1:0] v);
        return (int'(v) >= WORLD_Q) ? COORD_W'(COORD_TOP) : v;
    endfunction

    // coordinate widened to a signed multiplier operand
    function automatic logic signed [MUL_W-1:0] coord_s(input logic [COORD_W-1:0] v);
        return signed'({{(MUL_W - COORD_W){1'b0}}, v});
    endfunction

endpackage

`default_nettype wire

// ===== rtl/grid_ray_caster_unit.sv =====
// grid ray caster top level: wall map, cordic, slope divider, two grid marches and distance pick
`default_nettype none

// Usage
//   req channel (valid/ready) carries one grc_req_t transaction. operation OP_ROW_WRITE
//   loads one row of the 10x10 wall map in the accept cycle and returns nothing; a
//   row_index past the map is dropped. operation OP_CAST casts one ray and returns one
//   grc_rsp_t transaction on the rsp channel (valid/ready).
//   Cast sequence after acceptance: 16 cordic iterations, setup, two slope divisions
//   (only the saturation check when saturated), two marches of an init step plus the
//   multiply, add and test states per grid line tested, squared distances on the
//   shared 18x18 multiplier, and ST_DONE to load the result. A cast ends sooner when a march meets a
//   wall early or the angle sits on an axis. req_ready is high only while no cast is in
//   flight, so casts run one at a time; row writes go one per cycle while idle.
//   The result sits in an output register: the next transaction is taken while it waits.
//   A stalled receiver only holds a finished cast in its last cycle until the output
//   register frees up.
//   Reset (rst_n low, asynchronous) empties the wall map and drops any cast in flight.
module grid_ray_caster_unit
    import grc_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_ready,
    input  wire grc_req_t req,
    output logic          rsp_valid,
    input  wire logic     rsp_ready,
    output grc_rsp_t      rsp
);

    localparam logic signed [PROD_W-1:0]  WORLD_P   = PROD_W'(WORLD_Q);
    localparam logic signed [SLOPE_W-1:0] SLOPE_MAX = SLOPE_W'(SLOPE_CUT);

    // sequencer and control registers
    grc_state_t              state_reg, state_next;
    logic [GRID_CELLS-1:0]   map_reg [GRID_CELLS];
    logic [GRID_CELLS-1:0]   map_next [GRID_CELLS];
    logic                    rsp_valid_reg, rsp_valid_next;
    logic [ITER_W-1:0]       iter_reg, iter_next;
    logic [QCNT_W-1:0]       div_cnt_reg, div_cnt_next;
    logic [STEP_W-1:0]       step_reg, step_next;
    logic [DIST_W-1:0]       dist_cnt_reg, dist_cnt_next;
    logic                    div_sel_reg, div_sel_next;
    logic                    march_sel_reg, march_sel_next;

    // datapath registers
    logic [COORD_W-1:0]         px_reg, px_next, py_reg, py_next;
    logic [PHASE_W-1:0]         phase_reg, phase_next;
    logic signed [CORDIC_W-1:0] cx_reg, cx_next, cy_reg, cy_next, z_reg, z_next;
    logic [MAG_W-1:0]           cmag_reg, cmag_next, smag_reg, smag_next;
    logic                       xneg_reg, xneg_next, yneg_reg, yneg_next, sneg_reg, sneg_next;
    logic [MAG_W-1:0]           rem_reg, rem_next;
    logic [QUO_W-1:0]           quo_reg, quo_next, nbits_reg, nbits_next;
    logic signed [SLOPE_W-1:0]  tslope_reg, tslope_next, kslope_reg, kslope_next;
    logic [COORD_W-1:0]         a_reg, a_next, b_reg, b_next;
    logic [CELL_W-1:0]          acell_reg, acell_next;
    logic signed [PROD_W-1:0]   prod_reg, prod_next;
    logic [COORD_W-1:0]         vx_reg, vx_next, vy_reg, vy_next;
    logic [COORD_W-1:0]         hx_reg, hx_next, hy_reg, hy_next;
    logic [PROD_W-1:0]          accv_reg, accv_next, acch_reg, acch_next;
    grc_rsp_t                   rsp_reg, rsp_next;

    // shared multiplier
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_out;

    // combinational helpers
    logic [PHASE_W-1:0]         phase_in;
    logic signed [CORDIC_W-1:0] dx, dy, turn_s;
    logic [MAG_W-1:0]           cxm, cym, num_sel, den_sel;
    logic                       div_sat;
    logic [MAG_W:0]             trial;
    logic                       quo_bit;
    logic [QUO_W-1:0]           quo_new, fin_mag;
    logic                       slope_wr;
    logic signed [SLOPE_W-1:0]  slope_val, slope_sel;
    logic [COORD_W-1:0]         oa_sel, ob_sel;
    logic                       neg_sel;
    logic [CELL_W-1:0]          oa_cell, b_cell, ca_idx;
    logic                       out_of_map, wall_hit;
    logic signed [PROD_W-1:0]   bsum;
    logic signed [MUL_W-1:0]    diff_sel;
    logic                       vert_wins;

    assign mul_out = mul_a * mul_b;

    assign phase_in = PHASE_W'({req.ray_angle, {(PHASE_W - ANGLE_BITS){1'b0}}});

    // cordic shift unit
    assign dx     = cy_reg >>> iter_reg;
    assign dy     = cx_reg >>> iter_reg;
    assign turn_s = signed'({{(CORDIC_W - TURN_W){1'b0}}, cordic_turn(iter_reg)});
    assign cxm    = cx_reg[CORDIC_W-1] ? '0 : cx_reg[MAG_W-1:0];
    assign cym    = cy_reg[CORDIC_W-1] ? '0 : cy_reg[MAG_W-1:0];

    // divider operands: first pass tan, second pass cot
    assign num_sel = div_sel_reg ? cmag_reg : smag_reg;
    assign den_sel = div_sel_reg ? smag_reg : cmag_reg;
    assign div_sat = (den_sel == '0) ||
                     ({{(QUO_W - SLOPE_FRAC){1'b0}}, num_sel} >=
                      {den_sel, {(QUO_W - SLOPE_FRAC){1'b0}}});
    assign trial   = {rem_reg, nbits_reg[QUO_W-1]};
    assign quo_bit = trial >= {1'b0, den_sel};
    assign quo_new = {quo_reg[QUO_W-2:0], quo_bit};

    // march operands: vertical lines first, horizontal second
    assign oa_sel    = march_sel_reg ? py_reg : px_reg;
    assign ob_sel    = march_sel_reg ? px_reg : py_reg;
    assign neg_sel   = march_sel_reg ? yneg_reg : xneg_reg;
    assign slope_sel = march_sel_reg ? kslope_reg : tslope_reg;
    assign oa_cell   = cell_of(oa_sel);
    assign b_cell    = cell_of(b_reg);
    assign bsum      = (prod_reg >>> SLOPE_FRAC) +
                       signed'({{(PROD_W - COORD_W){1'b0}}, ob_sel});

    // wall test, the cell behind a line when moving negative
    assign out_of_map = neg_sel && (acell_reg == '0);
    assign ca_idx     = neg_sel ? (acell_reg - 1'b1) : acell_reg;
    assign wall_hit   = out_of_map ||
                        (march_sel_reg ? map_reg[ca_idx][b_cell] : map_reg[b_cell][ca_idx]);

    assign vert_wins = acch_reg > accv_reg;

    // distance operand per multiplier pass
    always_comb
    begin
        unique case (dist_cnt_reg)
            3'd0:    diff_sel = coord_s(vx_reg) - coord_s(px_reg);
            3'd1:    diff_sel = coord_s(vy_reg) - coord_s(py_reg);
            3'd2:    diff_sel = coord_s(hx_reg) - coord_s(px_reg);
            3'd3:    diff_sel = coord_s(hy_reg) - coord_s(py_reg);
            default: diff_sel = '0;
        endcase
    end

    // sequencer next state and datapath updates
    always_comb
    begin
        state_next     = state_reg;
        map_next       = map_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        iter_next      = iter_reg;
        div_cnt_next   = div_cnt_reg;
        step_next      = step_reg;
        dist_cnt_next  = dist_cnt_reg;
        div_sel_next   = div_sel_reg;
        march_sel_next = march_sel_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        phase_next     = phase_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        z_next         = z_reg;
        cmag_next      = cmag_reg;
        smag_next      = smag_reg;
        xneg_next      = xneg_reg;
        yneg_next      = yneg_reg;
        sneg_next      = sneg_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        nbits_next     = nbits_reg;
        tslope_next    = tslope_reg;
        kslope_next    = kslope_reg;
        a_next         = a_reg;
        acell_next     = acell_reg;
        b_next         = b_reg;
        prod_next      = prod_reg;
        vx_next        = vx_reg;
        vy_next        = vy_reg;
        hx_next        = hx_reg;
        hy_next        = hy_reg;
        accv_next      = accv_reg;
        acch_next      = acch_reg;
        rsp_next       = rsp_reg;
        mul_a          = '0;
        mul_b          = '0;
        req_ready      = 1'b0;
        slope_wr       = 1'b0;
        fin_mag        = '0;
        slope_val      = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    if (req.operation == OP_ROW_WRITE)
                    begin
                        if (req.row_index < ROW_IDX_W'(GRID_CELLS))
                        begin
                            map_next[req.row_index[CELL_W-1:0]] = req.row_bits[GRID_CELLS-1:0];
                        end
                    end
                    else
                    begin
                        px_next    = clamp_in(req.player_x);
                        py_next    = clamp_in(req.player_y);
                        phase_next = phase_in;
                        cx_next    = CORDIC_W'(CORDIC_START);
                        cy_next    = '0;
                        z_next     = signed'({{(CORDIC_W - RES_W){1'b0}}, phase_in[RES_W-1:0]});
                        iter_next  = '0;
                        state_next = (phase_in[RES_W-1:0] == '0) ? ST_SETUP : ST_CORDIC;
                    end
                end
            end

            // one rotation per cycle
            ST_CORDIC:
            begin
                if (!z_reg[CORDIC_W-1])
                begin
                    cx_next = cx_reg - dx;
                    cy_next = cy_reg + dy;
                    z_next  = z_reg - turn_s;
                end
                else
                begin
                    cx_next = cx_reg + dx;
                    cy_next = cy_reg - dy;
                    z_next  = z_reg + turn_s;
                end
                iter_next = iter_reg + 1'b1;
                if (iter_reg == ITER_W'(CORDIC_STEPS - 1))
                begin
                    state_next = ST_SETUP;
                end
            end

            // quadrant fold and direction signs
            ST_SETUP:
            begin
                cmag_next    = phase_reg[RES_W] ? cym : cxm;
                smag_next    = phase_reg[RES_W] ? cxm : cym;
                xneg_next    = (phase_reg > PHASE_W'(PHASE_QUARTER)) &&
                               (phase_reg < PHASE_W'(PHASE_3QUARTER));
                yneg_next    = phase_reg > PHASE_W'(PHASE_HALF);
                sneg_next    = ((phase_reg > PHASE_W'(PHASE_QUARTER)) &&
                                (phase_reg < PHASE_W'(PHASE_3QUARTER))) ^
                               (phase_reg > PHASE_W'(PHASE_HALF));
                div_sel_next = 1'b0;
                state_next   = ST_DIV_INIT;
            end

            // saturation check and divider load
            ST_DIV_INIT:
            begin
                if (div_sat)
                begin
                    slope_wr = 1'b1;
                    fin_mag  = QUO_W'(SLOPE_SAT);
                end
                else
                begin
                    rem_next     = MAG_W'(num_sel >> (QUO_W - SLOPE_FRAC));
                    nbits_next   = QUO_W'({num_sel, {SLOPE_FRAC{1'b0}}});
                    quo_next     = '0;
                    div_cnt_next = QCNT_W'(QUO_W - 1);
                    state_next   = ST_DIV_RUN;
                end
            end

            // restoring division, one quotient bit per cycle
            ST_DIV_RUN:
            begin
                rem_next     = quo_bit ? MAG_W'(trial - {1'b0, den_sel}) : MAG_W'(trial);
                quo_next     = quo_new;
                nbits_next   = nbits_reg << 1;
                div_cnt_next = div_cnt_reg - 1'b1;
                if (div_cnt_reg == '0)
                begin
                    slope_wr = 1'b1;
                    fin_mag  = (quo_new > QUO_W'(SLOPE_CUT)) ? QUO_W'(SLOPE_SAT) : quo_new;
                end
            end

            // first grid line from the origin cell
            ST_MARCH_INIT:
            begin
                step_next = '0;
                if (neg_sel)
                begin
                    a_next     = cell_base(oa_cell);
                    acell_next = oa_cell;
                end
                else if (oa_cell == CELL_W'(GRID_CELLS - 1))
                begin
                    a_next     = COORD_W'(COORD_TOP);
                    acell_next = CELL_W'(GRID_CELLS - 1);
                end
                else
                begin
                    a_next     = cell_base(oa_cell + 1'b1);
                    acell_next = oa_cell + 1'b1;
                end
                state_next = ST_MARCH_MUL;
            end

            // slope times distance along the stepped axis
            ST_MARCH_MUL:
            begin
                mul_a      = {{(MUL_W - SLOPE_W){slope_sel[SLOPE_W-1]}}, slope_sel};
                mul_b      = coord_s(a_reg) - coord_s(oa_sel);
                prod_next  = mul_out;
                state_next = ST_MARCH_ADD;
            end

            // cross coordinate with saturation
            ST_MARCH_ADD:
            begin
                if (bsum >= WORLD_P)
                begin
                    b_next = COORD_W'(COORD_TOP);
                end
                else if (bsum[PROD_W-1])
                begin
                    b_next = '0;
                end
                else
                begin
                    b_next = bsum[COORD_W-1:0];
                end
                state_next = ST_MARCH_TEST;
            end

            // wall test, keep the point, step to the next line
            ST_MARCH_TEST:
            begin
                if (march_sel_reg)
                begin
                    hy_next = a_reg;
                    hx_next = b_reg;
                end
                else
                begin
                    vx_next = a_reg;
                    vy_next = b_reg;
                end
                if (wall_hit || (step_reg == STEP_W'(MAX_STEPS - 1)))
                begin
                    if (!march_sel_reg)
                    begin
                        march_sel_next = 1'b1;
                        state_next     = ST_MARCH_INIT;
                    end
                    else
                    begin
                        dist_cnt_next = '0;
                        state_next    = ST_DIST;
                    end
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                    if (neg_sel)
                    begin
                        if (a_reg < COORD_W'(CELL_Q))
                        begin
                            a_next     = COORD_W'(NUDGE_Q);
                            acell_next = '0;
                        end
                        else
                        begin
                            a_next     = a_reg - COORD_W'(CELL_Q);
                            acell_next = acell_reg - 1'b1;
                        end
                    end
                    else
                    begin
                        if (a_reg >= COORD_W'(WORLD_Q - CELL_Q))
                        begin
                            a_next     = COORD_W'(COORD_TOP);
                            acell_next = CELL_W'(GRID_CELLS - 1);
                        end
                        else
                        begin
                            a_next     = a_reg + COORD_W'(CELL_Q);
                            acell_next = acell_reg + 1'b1;
                        end
                    end
                    state_next = ST_MARCH_MUL;
                end
            end

            // squared distances, one square per cycle, each summed in the following cycle
            ST_DIST:
            begin
                mul_a         = diff_sel;
                mul_b         = diff_sel;
                dist_cnt_next = dist_cnt_reg + 1'b1;
                unique case (dist_cnt_reg)
                    3'd0:
                    begin
                        prod_next = mul_out;
                    end
                    3'd1:
                    begin
                        prod_next = mul_out;
                        accv_next = prod_reg;
                    end
                    3'd2:
                    begin
                        prod_next = mul_out;
                        accv_next = accv_reg + prod_reg;
                    end
                    3'd3:
                    begin
                        prod_next = mul_out;
                        acch_next = prod_reg;
                    end
                    3'd4:
                    begin
                        acch_next  = acch_reg + prod_reg;
                        state_next = ST_DONE;
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end

            // pick the nearer hit, ties go to the horizontal march
            ST_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next.hit_x           = vert_wins ? vx_reg : hx_reg;
                    rsp_next.hit_y           = vert_wins ? vy_reg : hy_reg;
                    rsp_next.hit_on_vertical = vert_wins;
                    rsp_valid_next           = 1'b1;
                    state_next               = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // signed slope store after either division pass
        if (slope_wr)
        begin
            slope_val = sneg_reg ? -signed'({1'b0, fin_mag}) : signed'({1'b0, fin_mag});
            if (!div_sel_reg)
            begin
                tslope_next  = slope_val;
                div_sel_next = 1'b1;
                state_next   = ST_DIV_INIT;
            end
            else
            begin
                kslope_next    = slope_val;
                march_sel_next = 1'b0;
                state_next     = ST_MARCH_INIT;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            map_reg       <= '{default: '0};
            rsp_valid_reg <= 1'b0;
            iter_reg      <= '0;
            div_cnt_reg   <= '0;
            step_reg      <= '0;
            dist_cnt_reg  <= '0;
            div_sel_reg   <= 1'b0;
            march_sel_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            map_reg       <= map_next;
            rsp_valid_reg <= rsp_valid_next;
            iter_reg      <= iter_next;
            div_cnt_reg   <= div_cnt_next;
            step_reg      <= step_next;
            dist_cnt_reg  <= dist_cnt_next;
            div_sel_reg   <= div_sel_next;
            march_sel_reg <= march_sel_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        px_reg     <= px_next;
        py_reg     <= py_next;
        phase_reg  <= phase_next;
        cx_reg     <= cx_next;
        cy_reg     <= cy_next;
        z_reg      <= z_next;
        cmag_reg   <= cmag_next;
        smag_reg   <= smag_next;
        xneg_reg   <= xneg_next;
        yneg_reg   <= yneg_next;
        sneg_reg   <= sneg_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        nbits_reg  <= nbits_next;
        tslope_reg <= tslope_next;
        kslope_reg <= kslope_next;
        a_reg      <= a_next;
        acell_reg  <= acell_next;
        b_reg      <= b_next;
        prod_reg   <= prod_next;
        vx_reg     <= vx_next;
        vy_reg     <= vy_next;
        hx_reg     <= hx_next;
        hy_reg     <= hy_next;
        accv_reg   <= accv_next;
        acch_reg   <= acch_next;
        rsp_reg    <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef NO_ASSERTIONS
    // a cast transaction closes the input side on the next cycle
    a_cast_blocks_req: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && (req.operation == OP_CAST)) |=> !req_ready)
        else $error("input taken while a cast is in flight");

    // march step counter stays within the step budget
    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_MARCH_MUL) || (state_reg == ST_MARCH_ADD) ||
         (state_reg == ST_MARCH_TEST)) |-> (step_reg < STEP_W'(MAX_STEPS)))
        else $error("march ran past its step budget");

    // slopes used by a march are clamped
    a_slope_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MARCH_MUL) |-> ((slope_sel <= SLOPE_MAX) && (slope_sel >= -SLOPE_MAX)))
        else $error("march slope outside the clamp");

    // a result only appears after the final pick
    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside the final pick");
`endif

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// testbench of the grid ray caster: directed table, then random casts over changing wall maps
`timescale 1ns / 1ps

module tb;
    import grc_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int DRAIN_CYCLES  = 150;
    localparam int RANDOM_ITEMS  = 1200;
    localparam int ALL_WALLS     = (1 << GRID_CELLS) - 1;
    localparam int ANGLE_QUARTER = 1 << (ANGLE_BITS - 2);
    localparam int ORIGIN_Q      = 100 * FRAC_ONE;

    // predictor constants in 64-bit form
    localparam longint CELL_L  = longint'(CELL_Q);
    localparam longint WORLD_L = longint'(WORLD_Q);
    localparam longint TOP_L   = longint'(COORD_TOP);
    localparam longint NUDGE_L = longint'(NUDGE_Q);

    typedef struct packed {
        grc_req_t item;
        logic     known;
        grc_rsp_t known_hit;
    } probe_t;

    logic     clk;
    logic     rst_n;
    logic     req_valid;
    logic     req_ready;
    grc_req_t req;
    logic     rsp_valid;
    logic     rsp_ready;
    grc_rsp_t rsp;

    logic [GRID_CELLS-1:0] wall_rows [GRID_CELLS];
    grc_rsp_t              pending_hits [$];
    grc_rsp_t              oldest_hit;
    probe_t                probe_list [$];
    int                    mismatches;
    int                    cycle_count;
    logic                  calm;

    grid_ray_caster_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    // arctangent of 2^-i in 1/65536 turn
    function automatic longint arc_step(input int i);
        case (i)
            0:       return 8192;
            1:       return 4836;
            2:       return 2555;
            3:       return 1297;
            4:       return 651;
            5:       return 326;
            6:       return 163;
            7:       return 81;
            8:       return 41;
            9:       return 20;
            10:      return 10;
            11:      return 5;
            12:      return 3;
            13:      return 1;
            14:      return 1;
            default: return 0;
        endcase
    endfunction

    // saturate to the world, negative values go to the given floor
    function automatic longint clip_coord(input longint v, input longint floor_val);
        if (v >= WORLD_L) return TOP_L;
        if (v < 0) return floor_val;
        return v;
    endfunction

    // anything off the map is solid
    function automatic logic wall_at(input longint row, input longint col);
        if (row < 0 || row >= GRID_CELLS || col < 0 || col >= GRID_CELLS) return 1'b1;
        return wall_rows[int'(row)][int'(col)];
    endfunction

    // q7.8 slope magnitude with steep clamp
    function automatic longint slope_q8(input longint num, input longint den);
        longint m;
        if (den <= 0) return longint'(SLOPE_SAT);
        m = (num * 256) / den;
        return (m > SLOPE_CUT) ? longint'(SLOPE_SAT) : m;
    endfunction

    // march across grid lines of one orientation until a wall or the step limit
    function automatic void grid_march(input longint oa, input longint ob, input logic neg,
                                       input longint slope, input logic vert,
                                       output longint ha, output longint hb);
        longint a;
        longint b;
        longint ca;
        longint cb;
        longint stride;
        logic   hit;
        stride = neg ? -CELL_L : CELL_L;
        a = clip_coord((oa / CELL_L) * CELL_L + (neg ? 64'sd0 : CELL_L), NUDGE_L);
        ha = a;
        hb = ob;
        hit = 1'b0;
        for (int i = 0; i < MAX_STEPS && !hit; i++) begin
            b = clip_coord(ob + ((slope * (a - oa)) >>> SLOPE_FRAC), 0);
            ca = a / CELL_L - (neg ? 64'sd1 : 64'sd0);
            cb = b / CELL_L;
            ha = a;
            hb = b;
            hit = vert ? wall_at(cb, ca) : wall_at(ca, cb);
            if (!hit) a = clip_coord(a + stride, NUDGE_L);
        end
    endfunction

    // expected hit of one cast against the current wall map
    function automatic grc_rsp_t cast_ray(input grc_req_t item);
        logic [PHASE_W-1:0] phase;
        logic [1:0]         quad;
        longint             px, py, cx, cy, z, dx, dy;
        longint             cmag, smag, tmag, kmag;
        longint             vx, vy, hx, hy, dist_v, dist_h;
        logic               xneg, yneg, vert_wins;
        grc_rsp_t           hit;
        px = clip_coord(longint'(item.player_x), 0);
        py = clip_coord(longint'(item.player_y), 0);
        phase = PHASE_W'(item.ray_angle) << (PHASE_W - ANGLE_BITS);
        quad = phase[PHASE_W-1 -: 2];

        // cordic over the angle within its quadrant
        cx = CORDIC_START;
        cy = 0;
        if (phase[RES_W-1:0] != '0) begin
            z = longint'(phase[RES_W-1:0]);
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                dx = cy >>> i;
                dy = cx >>> i;
                if (z >= 0) begin
                    cx -= dx;
                    cy += dy;
                    z -= arc_step(i);
                end
                else begin
                    cx += dx;
                    cy -= dy;
                    z += arc_step(i);
                end
            end
            if (cx < 0) cx = 0;
            if (cy < 0) cy = 0;
        end
        cmag = quad[0] ? cy : cx;
        smag = quad[0] ? cx : cy;

        // direction signs, zero counts as positive
        xneg = (phase > PHASE_QUARTER) && (phase < PHASE_3QUARTER);
        yneg = phase > PHASE_HALF;
        tmag = slope_q8(smag, cmag);
        kmag = slope_q8(cmag, smag);
        if (xneg != yneg) begin
            tmag = -tmag;
            kmag = -kmag;
        end

        grid_march(px, py, xneg, tmag, 1'b1, vx, vy);
        grid_march(py, px, yneg, kmag, 1'b0, hy, hx);

        // nearer hit wins, horizontal on a tie
        dist_v = (vx - px) * (vx - px) + (vy - py) * (vy - py);
        dist_h = (hx - px) * (hx - px) + (hy - py) * (hy - py);
        vert_wins = dist_h > dist_v;
        hit.hit_x = COORD_W'(vert_wins ? vx : hx);
        hit.hit_y = COORD_W'(vert_wins ? vy : hy);
        hit.hit_on_vertical = vert_wins;
        return hit;
    endfunction

    // one row of the directed table
    function automatic void add_probe(input logic op, input int idx, input int bits,
                                      input int x, input int y, input int ang,
                                      input logic known, input int wx, input int wy,
                                      input logic wv);
        probe_t p;
        p.item.operation = op;
        p.item.row_index = ROW_IDX_W'(idx);
        p.item.row_bits = ROW_BITS_W'(bits);
        p.item.player_x = COORD_W'(x);
        p.item.player_y = COORD_W'(y);
        p.item.ray_angle = ANGLE_BITS'(ang);
        p.known = known;
        p.known_hit.hit_x = COORD_W'(wx);
        p.known_hit.hit_y = COORD_W'(wy);
        p.known_hit.hit_on_vertical = wv;
        probe_list.push_back(p);
    endfunction

    function automatic void check_field(input string name, input logic [COORD_W-1:0] want,
                                        input logic [COORD_W-1:0] got);
        if (got !== want) begin
            $error("%s expected %0d actual %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // drive one request transaction and record its expected result on acceptance
    task automatic issue(input grc_req_t item, input logic known, input grc_rsp_t known_hit);
        while (!calm && $urandom_range(0, 99) < 21) begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req <= item;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        if (item.operation == OP_CAST) begin
            pending_hits.push_back(known ? known_hit : cast_ray(item));
        end
        else if (item.row_index < GRID_CELLS) begin
            wall_rows[item.row_index] = item.row_bits[GRID_CELLS-1:0];
        end
    endtask

    // hold off the sender until every cast has returned
    task automatic drain_casts();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending_hits.size() != 0) @(posedge clk);
    endtask

    // result side: check each transaction, random back-pressure
    always @(posedge clk) begin
        if (rst_n) begin
            if (rsp_valid && rsp_ready) begin
                if (pending_hits.size() == 0) begin
                    $error("result with no cast outstanding: hit_x %0d hit_y %0d",
                           rsp.hit_x, rsp.hit_y);
                    mismatches++;
                end
                else begin
                    oldest_hit = pending_hits.pop_front();
                    check_field("hit_x", oldest_hit.hit_x, rsp.hit_x);
                    check_field("hit_y", oldest_hit.hit_y, rsp.hit_y);
                    check_field("hit_on_vertical", COORD_W'(oldest_hit.hit_on_vertical),
                                COORD_W'(rsp.hit_on_vertical));
                end
            end
            rsp_ready <= calm || ($urandom_range(0, 99) >= 21);
        end
    end

    // run limit
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** grid_ray_caster_unit: FAILED **");
            $finish;
        end
    end

    initial begin
        grc_req_t item;
        grc_rsp_t none;
        int       scene_mode;
        clk = 1'b0;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        rsp_ready = 1'b0;
        calm = 1'b0;
        mismatches = 0;
        cycle_count = 0;
        none = '0;
        for (int r = 0; r < GRID_CELLS; r++) wall_rows[r] = '0;

        // empty map: ray from the corner runs to the far edge
        add_probe(OP_CAST, 0, 0, 0, 0, 0, 1'b1, COORD_TOP, 0, 1'b1);
        // writes past the map are dropped
        add_probe(OP_ROW_WRITE, 15, ALL_WALLS, 0, 0, 0, 1'b0, 0, 0, 1'b0);
        add_probe(OP_ROW_WRITE, GRID_CELLS, ALL_WALLS, 0, 0, 0, 1'b0, 0, 0, 1'b0);
        add_probe(OP_CAST, 0, 0, 0, 0, 0, 1'b1, COORD_TOP, 0, 1'b1);
        // solid map
        for (int r = 0; r < GRID_CELLS; r++) begin
            add_probe(OP_ROW_WRITE, r, ALL_WALLS, 0, 0, 0, 1'b0, 0, 0, 1'b0);
        end
        // the four axis directions, zero cosine or sine
        add_probe(OP_CAST, 0, 0, ORIGIN_Q, ORIGIN_Q, 0, 1'b1,
                  2 * CELL_Q, ORIGIN_Q, 1'b1);
        add_probe(OP_CAST, 0, 0, ORIGIN_Q, ORIGIN_Q, ANGLE_QUARTER, 1'b1,
                  ORIGIN_Q, 2 * CELL_Q, 1'b0);
        add_probe(OP_CAST, 0, 0, ORIGIN_Q, ORIGIN_Q, 2 * ANGLE_QUARTER, 1'b1,
                  CELL_Q, ORIGIN_Q, 1'b1);
        add_probe(OP_CAST, 0, 0, ORIGIN_Q, ORIGIN_Q, 3 * ANGLE_QUARTER, 1'b1,
                  ORIGIN_Q, CELL_Q, 1'b0);
        // saturated origin, both marches land on it: tie goes horizontal
        add_probe(OP_CAST, 0, 0, 65535, 65535, 0, 1'b1, COORD_TOP, COORD_TOP, 1'b0);
        // open one row, then diagonal, near-axis and leftward rays
        add_probe(OP_ROW_WRITE, 4, 0, 0, 0, 0, 1'b0, 0, 0, 1'b0);
        add_probe(OP_CAST, 0, 0, 0, 0, ANGLE_QUARTER / 2, 1'b0, 0, 0, 1'b0);
        add_probe(OP_CAST, 0, 0, WORLD_Q - 1, WORLD_Q - 1, (1 << ANGLE_BITS) - 1,
                  1'b0, 0, 0, 1'b0);
        add_probe(OP_CAST, 0, 0, 20000, 4 * CELL_Q + 1000, 2 * ANGLE_QUARTER,
                  1'b0, 0, 0, 1'b0);
        add_probe(OP_CAST, 0, 0, 12345, 30000, 1, 1'b0, 0, 0, 1'b0);
        add_probe(OP_ROW_WRITE, 9, 10'h155, 0, 0, 0, 1'b0, 0, 0, 1'b0);
        add_probe(OP_CAST, 0, 0, 30000, 12345, 5 * ANGLE_QUARTER / 2, 1'b0, 0, 0, 1'b0);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed table
        foreach (probe_list[k]) begin
            issue(probe_list[k].item, probe_list[k].known, probe_list[k].known_hit);
        end
        drain_casts();

        // random part: new wall map every so often, mostly casts, some stray row writes
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            calm = (n >= 500 && n < 750);
            if (n == 300) drain_casts();
            item.operation = OP_CAST;
            item.row_index = ROW_IDX_W'($urandom);
            item.row_bits = ROW_BITS_W'($urandom);
            item.player_x = COORD_W'($urandom);
            item.player_y = COORD_W'($urandom);
            item.ray_angle = ANGLE_BITS'($urandom);
            if (n % 150 == 0) begin
                scene_mode = $urandom_range(0, 7);
                item.operation = OP_ROW_WRITE;
                for (int r = 0; r < GRID_CELLS; r++) begin
                    item.row_index = ROW_IDX_W'(r);
                    if (scene_mode == 0) item.row_bits = '0;
                    else if (scene_mode <= 3)
                        item.row_bits = ROW_BITS_W'($urandom & $urandom & $urandom);
                    else if (scene_mode <= 5)
                        item.row_bits = ROW_BITS_W'($urandom & $urandom);
                    else if (scene_mode == 6) item.row_bits = ROW_BITS_W'($urandom);
                    else item.row_bits = ROW_BITS_W'(ALL_WALLS);
                    issue(item, 1'b0, none);
                end
            end
            else if ($urandom_range(0, 9) == 0) begin
                // stray row write, index over the full field
                item.operation = OP_ROW_WRITE;
                issue(item, 1'b0, none);
            end
            else begin
                if ($urandom_range(0, 9) != 0) begin
                    item.player_x = COORD_W'($urandom_range(0, WORLD_Q - 1));
                    item.player_y = COORD_W'($urandom_range(0, WORLD_Q - 1));
                end
                if ($urandom_range(0, 7) == 0)
                    item.player_x = COORD_W'($urandom_range(0, GRID_CELLS) * CELL_Q);
                if ($urandom_range(0, 7) == 0)
                    item.player_y = COORD_W'($urandom_range(0, GRID_CELLS) * CELL_Q);
                // near-axis angles exercise the slope clamp
                if ($urandom_range(0, 4) == 0)
                    item.ray_angle = ANGLE_BITS'($urandom_range(0, 3) * ANGLE_QUARTER
                                                 + $urandom_range(0, 4) - 2);
                issue(item, 1'b0, none);
            end
        end
        calm = 1'b0;

        // wait out the last casts and watch for strays
        req_valid <= 1'b0;
        while (pending_hits.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0) begin
            $display("** grid_ray_caster_unit: PASSED **");
        end
        else begin
            $display("** grid_ray_caster_unit: FAILED **");
        end
        $finish;
    end

endmodule
